[design/crcfd_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 update for the frame deframer.
// No dependencies; every design file imports this package.
package crcfd_pkg;

   localparam int unsigned POS_W = 17;

   localparam logic [POS_W-1:0] POS_SYNC0    = 17'd0;
   localparam logic [POS_W-1:0] POS_SYNC1    = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd2;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd3;
   localparam logic [POS_W-1:0] POS_COMMAND  = 17'd4;
   localparam logic [POS_W-1:0] HEADER_BYTES = 17'd5;
   localparam logic [POS_W-1:0] TRAILER_BYTES = 17'd4;
   localparam logic [POS_W-1:0] POSITION_MAX = 17'h1FFFF;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [1:0] CSR_SECOND_SYNC = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH  = 2'd2;

   localparam logic [7:0]  FIRST_SYNC_RESET  = 8'd170;
   localparam logic [7:0]  SECOND_SYNC_RESET = 8'd85;
   localparam logic [15:0] MAX_LENGTH_RESET  = 16'd256;

   // verdict codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd2;

   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [7:0]  command_code;
      logic [15:0] payload_length;
      logic [31:0] received_crc;
      logic [1:0]  frame_status;
   } crcfd_result_type;

   typedef struct packed {
      logic [7:0]  first_sync;
      logic [7:0]  second_sync;
      logic [15:0] max_length;
   } crcfd_cfg_type;

   // reflected CRC-32, one byte, eight unrolled bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[design/crcfd_frame_ctrl.sv]
// Frame tracking state and per-byte decode: header checks, CRC, trailer, verdict.
// Depends on crcfd_pkg.
module crcfd_frame_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_valid,
   input  logic                       step,
   input  logic [7:0]                 data_byte,
   input  logic                       end_of_buffer,
   input  crcfd_pkg::crcfd_cfg_type   cfg,
   output logic                       result_valid,
   output crcfd_pkg::crcfd_result_type result
);
   import crcfd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      trl_ff, trl_in;
   logic             bad_ff, bad_in;
   logic             done_ff, done_in;

   logic [POS_W-1:0] pay_end;
   logic [POS_W-1:0] trl_end;
   logic [POS_W-1:0] pay_offset;
   logic             emit_pay;
   logic [1:0]       status;

   assign pay_end    = HEADER_BYTES + {1'b0, len_ff};
   assign trl_end    = pay_end + TRAILER_BYTES;
   assign pay_offset = pos_ff - HEADER_BYTES;

   always_comb begin
      len_in   = len_ff;
      cmd_in   = cmd_ff;
      crc_in   = crc_ff;
      trl_in   = trl_ff;
      bad_in   = bad_ff;
      done_in  = done_ff;
      emit_pay = 1'b0;
      if (pos_ff == POS_SYNC0) begin
         if (data_byte != cfg.first_sync) bad_in = 1'b1;
      end else if (pos_ff == POS_SYNC1) begin
         if (data_byte != cfg.second_sync) bad_in = 1'b1;
      end else if (pos_ff == POS_LEN_HI) begin
         len_in = {data_byte, 8'd0};
         crc_in = crc_byte(crc_ff, data_byte);
      end else if (pos_ff == POS_LEN_LO) begin
         len_in = {len_ff[15:8], data_byte};
         crc_in = crc_byte(crc_ff, data_byte);
         if ({len_ff[15:8], data_byte} > cfg.max_length) bad_in = 1'b1;
      end else if (pos_ff == POS_COMMAND) begin
         cmd_in = data_byte;
         crc_in = crc_byte(crc_ff, data_byte);
      end else if (pos_ff < pay_end) begin
         crc_in   = crc_byte(crc_ff, data_byte);
         emit_pay = !bad_ff;
      end else if (pos_ff < trl_end) begin
         trl_in = {trl_ff[23:0], data_byte};
         if (pos_ff == trl_end - 17'd1) done_in = 1'b1;
      end
      pos_in = (pos_ff != POSITION_MAX) ? pos_ff + 17'd1 : pos_ff;
   end

   always_comb begin
      if (bad_in || !done_in) begin
         status = STATUS_MALFORMED;
      end else if ((crc_in ^ CRC_INIT) != trl_in) begin
         status = STATUS_CRC_ERROR;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result_valid = byte_valid && (end_of_buffer || emit_pay);
      if (end_of_buffer) begin
         result.is_verdict     = 1'b1;
         result.payload_byte   = 8'd0;
         result.payload_index  = 16'd0;
         result.command_code   = cmd_in;
         result.payload_length = len_in;
         result.received_crc   = trl_in;
         result.frame_status   = status;
      end else begin
         result.is_verdict     = 1'b0;
         result.payload_byte   = data_byte;
         result.payload_index  = pay_offset[15:0];
         result.command_code   = cmd_ff;
         result.payload_length = len_ff;
         result.received_crc   = 32'd0;
         result.frame_status   = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_buffer)) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         cmd_ff  <= '0;
         crc_ff  <= CRC_INIT;
         trl_ff  <= '0;
         bad_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         cmd_ff  <= cmd_in;
         crc_ff  <= crc_in;
         trl_ff  <= trl_in;
         bad_ff  <= bad_in;
         done_ff <= done_in;
      end
   end

endmodule

[design/crcfd_rsp_reg.sv]
// Result register on the rsp channel; frees itself in the cycle the beat is taken.
// Depends on crcfd_pkg.
module crcfd_rsp_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  crcfd_pkg::crcfd_result_type load_data,
   input  logic                        rsp_ready,
   output logic                        free,
   output logic                        rsp_valid,
   output crcfd_pkg::crcfd_result_type rsp_data
);
   import crcfd_pkg::*;

   logic             valid_ff, valid_in;
   crcfd_result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

[design/crc_frame_deframer_core.sv]
// Path: a req beat lands in the input register, is decoded there and its result is loaded
// into the rsp result register. Throughput: one byte per cycle unless a result waits on a
// full result register, set by the unrolled byte-wide CRC update between the two registers.
// Reset (synchronous, active high): frame state cleared, CRC at all ones, config at defaults.
// Depends on crcfd_pkg, crcfd_frame_ctrl, crcfd_rsp_reg.
module crc_frame_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_verdict,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [7:0]  rsp_command_code,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_received_crc,
   output logic [1:0]  rsp_frame_status,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import crcfd_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   crcfd_cfg_type    cfg_ff;
   crcfd_result_type result;
   crcfd_result_type rsp_data;
   logic             result_valid;
   logic             out_free;
   logic             advance;
   logic             req_take;

   // Advance the held byte when it makes no result, or when the result register can take it.
   assign advance     = in_valid_ff && (!result_valid || out_free);
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold payload until the next beat is accepted
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_end_of_buffer;
      end
   end

   // Configuration registers; indexes past the list drop silently.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_sync  <= FIRST_SYNC_RESET;
         cfg_ff.second_sync <= SECOND_SYNC_RESET;
         cfg_ff.max_length  <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_SYNC:  cfg_ff.first_sync  <= csr_data[7:0];
            CSR_SECOND_SYNC: cfg_ff.second_sync <= csr_data[7:0];
            CSR_MAX_LENGTH:  cfg_ff.max_length  <= csr_data;
            default: ;
         endcase
      end
   end

   crcfd_frame_ctrl u_frame_ctrl (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (in_valid_ff),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .cfg           (cfg_ff),
      .result_valid  (result_valid),
      .result        (result)
   );

   crcfd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && result_valid),
      .load_data (result),
      .rsp_ready (rsp_ready),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_is_verdict     = rsp_data.is_verdict;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_payload_index  = rsp_data.payload_index;
   assign rsp_command_code   = rsp_data.command_code;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_received_crc   = rsp_data.received_crc;
   assign rsp_frame_status   = rsp_data.frame_status;

endmodule

[test/crc_frame_deframer_core_tb.sv]
// Self-checking testbench for crc_frame_deframer_core: frames, broken frames and noise
// go in byte by byte, every rsp beat is checked against an in-bench predictor.
// Depends on crcfd_pkg and the crc_frame_deframer_core RTL.
module crc_frame_deframer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crcfd_pkg::*;

   // index that maps to no register; the block must ignore writes to it
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // random bytes per configuration phase
   localparam int PHASE_BYTES = 412;

   typedef enum int {
      FR_GOOD, FR_BAD_CRC, FR_BAD_SYNC, FR_OVERSIZE, FR_TRUNC, FR_TAIL_JUNK, FR_NOISE
   } frame_kind_type;

   // Predicts the rsp beats of the deframer and holds them until they arrive.
   class rsp_book_type;
      logic [7:0]  sync_a;
      logic [7:0]  sync_b;
      logic [15:0] len_limit;
      logic [16:0] pos;
      logic [15:0] len_hdr;
      logic [7:0]  cmd_hdr;
      logic [31:0] crc_acc;
      logic [31:0] crc_tail;
      bit          bad;
      bit          closed;
      crcfd_result_type rsp_due[$];
      int unsigned miss_count;

      function new();
         sync_a = FIRST_SYNC_RESET;
         sync_b = SECOND_SYNC_RESET;
         len_limit = MAX_LENGTH_RESET;
         miss_count = 0;
         rearm();
      endfunction

      // reflected CRC-32, data bits folded in LSB first
      static function logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
         logic [31:0] r;
         r = acc;
         for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i]) begin
               r = (r >> 1) ^ CRC_POLY;
            end else begin
               r = r >> 1;
            end
         end
         return r;
      endfunction

      function void rearm();
         pos = '0;
         len_hdr = '0;
         cmd_hdr = '0;
         crc_acc = CRC_INIT;
         crc_tail = '0;
         bad = 1'b0;
         closed = 1'b0;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic [15:0] val);
         case (idx)
            CSR_FIRST_SYNC:  sync_a = val[7:0];
            CSR_SECOND_SYNC: sync_b = val[7:0];
            CSR_MAX_LENGTH:  len_limit = val;
            default: ;
         endcase
      endfunction

      function void take_byte(input logic [7:0] b, input logic last);
         logic [16:0] pay_end;
         crcfd_result_type r;
         bit emit;
         pay_end = HEADER_BYTES + {1'b0, len_hdr};
         r = '0;
         emit = 1'b0;
         if (pos == POS_SYNC0) begin
            if (b != sync_a) bad = 1'b1;
         end else if (pos == POS_SYNC1) begin
            if (b != sync_b) bad = 1'b1;
         end else if (pos == POS_LEN_HI) begin
            len_hdr = {b, 8'h00};
            crc_acc = crc_step(crc_acc, b);
         end else if (pos == POS_LEN_LO) begin
            len_hdr[7:0] = b;
            crc_acc = crc_step(crc_acc, b);
            if (len_hdr > len_limit) bad = 1'b1;
         end else if (pos == POS_COMMAND) begin
            cmd_hdr = b;
            crc_acc = crc_step(crc_acc, b);
         end else if (pos < pay_end) begin
            crc_acc = crc_step(crc_acc, b);
            if (!bad) begin
               emit = 1'b1;
               r.payload_byte = b;
               r.payload_index = 16'(pos - HEADER_BYTES);
               r.command_code = cmd_hdr;
               r.payload_length = len_hdr;
            end
         end else if (pos < pay_end + TRAILER_BYTES) begin
            crc_tail = {crc_tail[23:0], b};
            if (pos == pay_end + TRAILER_BYTES - 17'd1) closed = 1'b1;
         end
         if (pos != POSITION_MAX) pos = pos + 17'd1;

         if (last) begin
            r = '0;
            r.is_verdict = 1'b1;
            r.command_code = cmd_hdr;
            r.payload_length = len_hdr;
            r.received_crc = crc_tail;
            if (bad || !closed) begin
               r.frame_status = STATUS_MALFORMED;
            end else if (~crc_acc != crc_tail) begin
               r.frame_status = STATUS_CRC_ERROR;
            end else begin
               r.frame_status = STATUS_OK;
            end
            rsp_due.push_back(r);
            rearm();
         end else if (emit) begin
            rsp_due.push_back(r);
         end
      endfunction

      function string show(input crcfd_result_type r);
         return $sformatf("verdict=%0d byte=%02h idx=%0d cmd=%02h len=%0d crc=%08h status=%0d",
                          r.is_verdict, r.payload_byte, r.payload_index, r.command_code,
                          r.payload_length, r.received_crc, r.frame_status);
      endfunction

      function void match_rsp(input crcfd_result_type got);
         crcfd_result_type want;
         bit differs;
         if (rsp_due.size() == 0) begin
            miss_count++;
            if (miss_count <= 10) $display("rsp beat with nothing pending: %s", show(got));
            return;
         end
         want = rsp_due.pop_front();
         differs = (got.is_verdict !== want.is_verdict) ||
                   (got.payload_byte !== want.payload_byte) ||
                   (got.payload_index !== want.payload_index) ||
                   (got.command_code !== want.command_code) ||
                   (got.payload_length !== want.payload_length) ||
                   (got.received_crc !== want.received_crc) ||
                   (got.frame_status !== want.frame_status);
         if (differs) begin
            miss_count++;
            if (miss_count <= 10) begin
               $display("rsp mismatch at %0t", $realtime);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_verdict;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_payload_index;
   logic [7:0]  rsp_command_code;
   logic [15:0] rsp_payload_length;
   logic [31:0] rsp_received_crc;
   logic [1:0]  rsp_frame_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // bench-side copy of the registers, used only to build frames
   logic [7:0]  cfg_sync_a = FIRST_SYNC_RESET;
   logic [7:0]  cfg_sync_b = SECOND_SYNC_RESET;
   logic [15:0] cfg_max_len = MAX_LENGTH_RESET;

   logic [7:0]  frame_bytes[$];
   bit          tx_burst = 1'b0;
   rsp_book_type book;

   crc_frame_deframer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_verdict     (rsp_is_verdict),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_received_crc   (rsp_received_crc),
      .rsp_frame_status   (rsp_frame_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Watch all three channels at the clock edge. Values read here are the ones that
   // stood before the edge, so every handshake is seen exactly as the block sees it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            book.match_rsp({rsp_is_verdict, rsp_payload_byte, rsp_payload_index,
                            rsp_command_code, rsp_payload_length, rsp_received_crc,
                            rsp_frame_status});
         end
         if (req_valid && req_ready) book.take_byte(req_data_byte, req_end_of_buffer);
         if (csr_valid && csr_ready) book.write_reg(csr_index, csr_data);
      end
   end

   // Result sink: stretches of steady ready alternate with stretches of random stalls,
   // most of them short, some long.
   initial begin : rsp_sink
      int hold;
      int mode_left;
      int r;
      bit steady;
      hold = 0;
      mode_left = 0;
      steady = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         if (steady) begin
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 25) begin
               hold = $urandom_range(1, 3);
            end else if (r < 30) begin
               hold = $urandom_range(4, 40);
            end
         end
      end
   end

   // Idle cycles before the next req beat: none during a burst buffer, else mostly short.
   function automatic int pick_gap();
      int r;
      if (tx_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Offer one byte and hold it until accepted. With no gap, valid stays high and
   // only the payload advances, so valid sees a single assignment per edge.
   task automatic send_byte(input logic [7:0] d, input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_end_of_buffer <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every pending rsp beat is in, then idle extra cycles
   // to cover bytes still in flight that produce no beat.
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (book.rsp_due.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Send frame_bytes as one buffer, flagging the last byte; optionally pause after
   // byte pause_at until the block has drained.
   task automatic send_buffer(input int pause_at);
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, pick_gap());
         if (i == pause_at) settle(0);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FIRST_SYNC:  cfg_sync_a = val[7:0];
         CSR_SECOND_SYNC: cfg_sync_b = val[7:0];
         CSR_MAX_LENGTH:  cfg_max_len = val;
         default: ;
      endcase
   endtask

   task automatic push_header(input logic [15:0] len, input logic [7:0] cmd);
      frame_bytes.push_back(cfg_sync_a);
      frame_bytes.push_back(cfg_sync_b);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(cmd);
   endtask

   // CRC over everything after the sync pair, appended big-endian
   task automatic append_crc();
      logic [31:0] crc;
      crc = CRC_INIT;
      for (int i = 2; i < frame_bytes.size(); i++) begin
         crc = rsp_book_type::crc_step(crc, frame_bytes[i]);
      end
      crc = ~crc;
      frame_bytes.push_back(crc[31:24]);
      frame_bytes.push_back(crc[23:16]);
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(crc[7:0]);
   endtask

   task automatic build_frame(input frame_kind_type kind);
      logic [15:0] len;
      logic [7:0] cmd;
      int cap;
      int n;
      int at;
      frame_kind_type k;
      frame_bytes.delete();
      k = kind;
      // no length can exceed the limit once the limit is at its top
      if (k == FR_OVERSIZE && cfg_max_len == 16'hFFFF) k = FR_BAD_SYNC;
      cap = (cfg_max_len < 12) ? int'(cfg_max_len) : 12;
      if ($urandom_range(0, 19) == 0) cap = (cfg_max_len < 300) ? int'(cfg_max_len) : 300;
      len = 16'($urandom_range(0, cap));
      cmd = 8'($urandom);
      case (k)
         FR_NOISE: begin
            if ($urandom_range(0, 1) == 1) begin
               frame_bytes.push_back(cfg_sync_a);
               frame_bytes.push_back(cfg_sync_b);
            end
            n = $urandom_range(1, 10);
            repeat (n) frame_bytes.push_back(8'($urandom));
         end
         FR_OVERSIZE: begin
            len = 16'($urandom_range(int'(cfg_max_len) + 1, 65535));
            push_header(len, cmd);
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
         end
         default: begin
            if (k == FR_TRUNC && $urandom_range(0, 3) == 0) begin
               // any length at all, buffer ends shortly after the header
               push_header(16'($urandom), cmd);
               repeat ($urandom_range(0, 8)) frame_bytes.push_back(8'($urandom));
            end else begin
               push_header(len, cmd);
               repeat (len) frame_bytes.push_back(8'($urandom));
               append_crc();
               case (k)
                  FR_BAD_SYNC: begin
                     at = $urandom_range(0, 1);
                     frame_bytes[at] = frame_bytes[at] ^ 8'($urandom_range(1, 255));
                  end
                  FR_BAD_CRC: begin
                     at = $urandom_range(4, frame_bytes.size() - 1);
                     frame_bytes[at] = frame_bytes[at] ^ (8'd1 << $urandom_range(0, 7));
                  end
                  FR_TRUNC: begin
                     n = $urandom_range(1, frame_bytes.size() - 1);
                     while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
                  end
                  FR_TAIL_JUNK: begin
                     repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
                  end
                  default: ;
               endcase
            end
         end
      endcase
   endtask

   // Mostly well-formed frames with random content, the rest broken frames and noise.
   // Pause once per phase in the middle of a buffer until the block has drained.
   task automatic run_random(input int budget);
      int sent;
      int r;
      int pause_at;
      frame_kind_type kind;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(0, 99);
         if (r < 56)      kind = FR_GOOD;
         else if (r < 66) kind = FR_BAD_CRC;
         else if (r < 72) kind = FR_BAD_SYNC;
         else if (r < 78) kind = FR_OVERSIZE;
         else if (r < 88) kind = FR_TRUNC;
         else if (r < 94) kind = FR_TAIL_JUNK;
         else             kind = FR_NOISE;
         build_frame(kind);
         tx_burst = ($urandom_range(0, 5) == 0);
         pause_at = -1;
         if (sent < budget / 2 && sent + frame_bytes.size() >= budget / 2) begin
            pause_at = frame_bytes.size() / 2;
         end
         send_buffer(pause_at);
         sent += frame_bytes.size();
      end
   endtask

   initial begin
      book = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks under the reset register values.
      // good frame, command and payload at their extremes
      frame_bytes.delete();
      push_header(16'd2, 8'hFF);
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(8'hFF);
      append_crc();
      send_buffer(-1);
      // a single byte that ends the buffer
      frame_bytes.delete();
      frame_bytes.push_back(cfg_sync_a);
      send_buffer(-1);
      // wrong first sync byte
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      frame_bytes.push_back(cfg_sync_b);
      send_buffer(-1);
      // length one above the limit; the payload byte carries end of buffer
      frame_bytes.delete();
      push_header(cfg_max_len + 16'd1, 8'h00);
      frame_bytes.push_back(8'h5A);
      send_buffer(-1);
      // good empty frame followed by a few trailing bytes, sent back to back
      frame_bytes.delete();
      push_header(16'd0, 8'h3C);
      append_crc();
      repeat (6) frame_bytes.push_back(8'($urandom));
      tx_burst = 1'b1;
      send_buffer(-1);

      run_random(PHASE_BYTES);

      // sync extremes, no payload allowed
      settle(8);
      csr_write(CSR_FIRST_SYNC, {8'($urandom), 8'h00});
      csr_write(CSR_SECOND_SYNC, {8'($urandom), 8'hFF});
      csr_write(CSR_MAX_LENGTH, 16'h0000);
      run_random(PHASE_BYTES);

      // opposite sync extremes, any length allowed; poke the unmapped index too
      settle(8);
      csr_write(CSR_FIRST_SYNC, {8'($urandom), 8'hFF});
      csr_write(CSR_SECOND_SYNC, {8'($urandom), 8'h00});
      csr_write(CSR_MAX_LENGTH, 16'hFFFF);
      csr_write(CSR_UNUSED, 16'($urandom));
      run_random(PHASE_BYTES);

      // random syncs, a small limit
      settle(8);
      csr_write(CSR_FIRST_SYNC, 16'($urandom));
      csr_write(CSR_SECOND_SYNC, 16'($urandom));
      csr_write(CSR_MAX_LENGTH, 16'($urandom_range(1, 40)));
      run_random(PHASE_BYTES);

      // drain, then idle on so that any stray beat can still show
      settle(10);
      if (book.miss_count == 0 && book.rsp_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
design/crcfd_pkg.sv
design/crcfd_frame_ctrl.sv
design/crcfd_rsp_reg.sv
design/crc_frame_deframer_core.sv
test/crc_frame_deframer_core_tb.sv
